// ----- rtl/core/rgb2g_pkg.sv -----
package rgb2g_pkg;

  typedef enum logic [3:0] {
    MODE_AVERAGE   = 4'd0,
    MODE_BT240     = 4'd1,
    MODE_MAX       = 4'd2,
    MODE_MIN       = 4'd3,
    MODE_BT709     = 4'd4,
    MODE_LIGHTNESS = 4'd5,
    MODE_LUMA      = 4'd6,
    MODE_RMY       = 4'd7,
    MODE_WEIGHTED  = 4'd8
  } gray_mode_e;

  localparam int CFG_INDEX_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRAY_MODE    = 4'd0,
    REG_WEIGHT_RED   = 4'd1,
    REG_WEIGHT_GREEN = 4'd2,
    REG_WEIGHT_BLUE  = 4'd3
  } cfg_reg_e;

  localparam int MODE_W          = 4;
  localparam int WEIGHT_W        = 16;
  localparam int FIXED_COEF_W    = 17;
  localparam int COEF_W          = 18;
  localparam int FIXED_FRAC_BITS = 16;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd5461;

  typedef logic [FIXED_COEF_W-1:0] fixed_coef_t;

  localparam fixed_coef_t K_BT709 [3] = '{17'd13933, 17'd46871, 17'd4732};
  localparam fixed_coef_t K_BT240 [3] = '{17'd13894, 17'd45941, 17'd5702};
  localparam fixed_coef_t K_LUMA  [3] = '{17'd19661, 17'd38666, 17'd7209};
  localparam fixed_coef_t K_RMY   [3] = '{17'd32768, 17'd27460, 17'd5308};

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [WEIGHT_W-1:0] weight_red;
    logic signed [WEIGHT_W-1:0] weight_green;
    logic signed [WEIGHT_W-1:0] weight_blue;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [MODE_W-1:0] mode;
  } pipe_ctl_t;

endpackage

// ----- rtl/core/rgb2g_cfg.sv -----
module rgb2g_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rgb2g_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [rgb2g_pkg::WEIGHT_W-1:0]       cfg_data_i,
  output rgb2g_pkg::cfg_t                      cfg_o
);

  rgb2g_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rgb2g_pkg::REG_GRAY_MODE: begin
          cfg_d.mode = cfg_data_i[rgb2g_pkg::MODE_W-1:0];
        end
        rgb2g_pkg::REG_WEIGHT_RED: begin
          cfg_d.weight_red = signed'(cfg_data_i);
        end
        rgb2g_pkg::REG_WEIGHT_GREEN: begin
          cfg_d.weight_green = signed'(cfg_data_i);
        end
        rgb2g_pkg::REG_WEIGHT_BLUE: begin
          cfg_d.weight_blue = signed'(cfg_data_i);
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= rgb2g_pkg::MODE_AVERAGE;
      cfg_q.weight_red   <= rgb2g_pkg::WEIGHT_RESET;
      cfg_q.weight_green <= rgb2g_pkg::WEIGHT_RESET;
      cfg_q.weight_blue  <= rgb2g_pkg::WEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/rgb2g_prod.sv -----
module rgb2g_prod #(
  parameter int CHANNEL_BITS = 8,
  localparam int PROD_W      = rgb2g_pkg::COEF_W + CHANNEL_BITS + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic                            last_i,
  input  logic [CHANNEL_BITS-1:0]         red_i,
  input  logic [CHANNEL_BITS-1:0]         green_i,
  input  logic [CHANNEL_BITS-1:0]         blue_i,
  input  rgb2g_pkg::cfg_t                 cfg_i,
  output rgb2g_pkg::pipe_ctl_t            ctl_o,
  output logic signed [PROD_W-1:0]        prod_o [3],
  output logic [CHANNEL_BITS+1:0]         sum_o,
  output logic [CHANNEL_BITS-1:0]         min_o,
  output logic [CHANNEL_BITS-1:0]         max_o
);

  logic signed [rgb2g_pkg::COEF_W-1:0] coef [3];
  logic signed [CHANNEL_BITS:0]        chan [3];
  logic [rgb2g_pkg::WEIGHT_W-1:0]      weight [3];
  logic [CHANNEL_BITS-1:0]             min_rg, max_rg;

  rgb2g_pkg::pipe_ctl_t                ctl_d, ctl_q;
  logic signed [PROD_W-1:0]            prod_d [3];
  logic signed [PROD_W-1:0]            prod_q [3];
  logic [CHANNEL_BITS+1:0]             sum_d, sum_q;
  logic [CHANNEL_BITS-1:0]             min_d, min_q, max_d, max_q;

  assign chan[0] = signed'({1'b0, red_i});
  assign chan[1] = signed'({1'b0, green_i});
  assign chan[2] = signed'({1'b0, blue_i});

  assign weight[0] = cfg_i.weight_red;
  assign weight[1] = cfg_i.weight_green;
  assign weight[2] = cfg_i.weight_blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (cfg_i.mode)
        rgb2g_pkg::MODE_BT240: coef[i] = signed'({1'b0, rgb2g_pkg::K_BT240[i]});
        rgb2g_pkg::MODE_BT709: coef[i] = signed'({1'b0, rgb2g_pkg::K_BT709[i]});
        rgb2g_pkg::MODE_LUMA:  coef[i] = signed'({1'b0, rgb2g_pkg::K_LUMA[i]});
        rgb2g_pkg::MODE_RMY:   coef[i] = signed'({1'b0, rgb2g_pkg::K_RMY[i]});
        rgb2g_pkg::MODE_WEIGHTED: begin
          coef[i] = signed'({{2{weight[i][rgb2g_pkg::WEIGHT_W-1]}}, weight[i]});
        end
        default: coef[i] = '0;
      endcase
      prod_d[i] = PROD_W'(coef[i] * chan[i]);
    end
  end

  always_comb begin
    min_rg = (red_i < green_i) ? red_i : green_i;
    max_rg = (red_i > green_i) ? red_i : green_i;
    min_d  = (min_rg < blue_i) ? min_rg : blue_i;
    max_d  = (max_rg > blue_i) ? max_rg : blue_i;
    sum_d  = (CHANNEL_BITS+2)'(red_i) + (CHANNEL_BITS+2)'(green_i)
           + (CHANNEL_BITS+2)'(blue_i);
    ctl_d.valid = valid_i;
    ctl_d.last  = last_i;
    ctl_d.mode  = cfg_i.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    min_q  <= min_d;
    max_q  <= max_d;
  end

  assign ctl_o  = ctl_q;
  assign prod_o = prod_q;
  assign sum_o  = sum_q;
  assign min_o  = min_q;
  assign max_o  = max_q;

endmodule

// ----- rtl/core/rgb2g_sum.sv -----
module rgb2g_sum #(
  parameter int CHANNEL_BITS     = 8,
  parameter int WEIGHT_FRAC_BITS = 14,
  localparam int PROD_W          = rgb2g_pkg::COEF_W + CHANNEL_BITS + 1,
  localparam int ACC_W           = PROD_W + 2,
  localparam int DIV_SHIFT       = ((CHANNEL_BITS + 4) / 2) * 2,
  localparam int AVG_W           = CHANNEL_BITS + 2 + DIV_SHIFT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgb2g_pkg::pipe_ctl_t          ctl_i,
  input  logic signed [PROD_W-1:0]      prod_i [3],
  input  logic [CHANNEL_BITS+1:0]       sum_i,
  input  logic [CHANNEL_BITS-1:0]       min_i,
  input  logic [CHANNEL_BITS-1:0]       max_i,
  output rgb2g_pkg::pipe_ctl_t          ctl_o,
  output logic signed [ACC_W-1:0]       acc_o,
  output logic [AVG_W-1:0]              avg_prod_o,
  output logic [CHANNEL_BITS-1:0]       light_o,
  output logic [CHANNEL_BITS-1:0]       min_o,
  output logic [CHANNEL_BITS-1:0]       max_o
);

  localparam logic [DIV_SHIFT-1:0] DIV_MULT = DIV_SHIFT'(((1 << DIV_SHIFT) + 2) / 3);
  localparam logic signed [ACC_W-1:0] RND_WEIGHTED =
    {{(ACC_W-1){1'b0}}, 1'b1} << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_FIXED =
    {{(ACC_W-1){1'b0}}, 1'b1} << (rgb2g_pkg::FIXED_FRAC_BITS - 1);

  logic signed [ACC_W-1:0]   rnd;
  logic [CHANNEL_BITS+1:0]   avg_num;
  logic [CHANNEL_BITS:0]     light_sum;

  rgb2g_pkg::pipe_ctl_t      ctl_q;
  logic signed [ACC_W-1:0]   acc_d, acc_q;
  logic [AVG_W-1:0]          avg_prod_d, avg_prod_q;
  logic [CHANNEL_BITS-1:0]   light_d, light_q, min_q, max_q;

  always_comb begin
    rnd        = (ctl_i.mode == rgb2g_pkg::MODE_WEIGHTED) ? RND_WEIGHTED : RND_FIXED;
    acc_d      = ACC_W'(prod_i[0]) + ACC_W'(prod_i[1]) + ACC_W'(prod_i[2]) + rnd;
    avg_num    = sum_i + (CHANNEL_BITS+2)'(1);
    avg_prod_d = AVG_W'(avg_num) * AVG_W'(DIV_MULT);
    light_sum  = (CHANNEL_BITS+1)'(min_i) + (CHANNEL_BITS+1)'(max_i)
               + (CHANNEL_BITS+1)'(1);
    light_d    = light_sum[CHANNEL_BITS:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    avg_prod_q <= avg_prod_d;
    light_q    <= light_d;
    min_q      <= min_i;
    max_q      <= max_i;
  end

  assign ctl_o      = ctl_q;
  assign acc_o      = acc_q;
  assign avg_prod_o = avg_prod_q;
  assign light_o    = light_q;
  assign min_o      = min_q;
  assign max_o      = max_q;

endmodule

// ----- rtl/core/rgb2g_out.sv -----
module rgb2g_out #(
  parameter int CHANNEL_BITS     = 8,
  parameter int WEIGHT_FRAC_BITS = 14,
  localparam int ACC_W           = rgb2g_pkg::COEF_W + CHANNEL_BITS + 3,
  localparam int DIV_SHIFT       = ((CHANNEL_BITS + 4) / 2) * 2,
  localparam int AVG_W           = CHANNEL_BITS + 2 + DIV_SHIFT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgb2g_pkg::pipe_ctl_t          ctl_i,
  input  logic signed [ACC_W-1:0]       acc_i,
  input  logic [AVG_W-1:0]              avg_prod_i,
  input  logic [CHANNEL_BITS-1:0]       light_i,
  input  logic [CHANNEL_BITS-1:0]       min_i,
  input  logic [CHANNEL_BITS-1:0]       max_i,
  output logic                          valid_o,
  output logic                          last_o,
  output logic [CHANNEL_BITS-1:0]       gray_o,
  output logic                          sat_o
);

  localparam logic signed [ACC_W-1:0] CH_MAX_S =
    signed'(ACC_W'({CHANNEL_BITS{1'b1}}));

  logic signed [ACC_W-1:0]   scaled;
  logic [CHANNEL_BITS-1:0]   clamp_val;
  logic                      clamp_sat;

  logic                      valid_q, last_q, sat_d, sat_q;
  logic [CHANNEL_BITS-1:0]   gray_d, gray_q;

  always_comb begin
    if (ctl_i.mode == rgb2g_pkg::MODE_WEIGHTED) begin
      scaled = acc_i >>> WEIGHT_FRAC_BITS;
    end else begin
      scaled = acc_i >>> rgb2g_pkg::FIXED_FRAC_BITS;
    end
    if (scaled < 0) begin
      clamp_val = '0;
      clamp_sat = 1'b1;
    end else if (scaled > CH_MAX_S) begin
      clamp_val = '1;
      clamp_sat = 1'b1;
    end else begin
      clamp_val = scaled[CHANNEL_BITS-1:0];
      clamp_sat = 1'b0;
    end
  end

  always_comb begin
    sat_d = 1'b0;
    case (ctl_i.mode)
      rgb2g_pkg::MODE_AVERAGE:   gray_d = avg_prod_i[DIV_SHIFT +: CHANNEL_BITS];
      rgb2g_pkg::MODE_MAX:       gray_d = max_i;
      rgb2g_pkg::MODE_MIN:       gray_d = min_i;
      rgb2g_pkg::MODE_LIGHTNESS: gray_d = light_i;
      rgb2g_pkg::MODE_BT240, rgb2g_pkg::MODE_BT709, rgb2g_pkg::MODE_LUMA,
      rgb2g_pkg::MODE_RMY, rgb2g_pkg::MODE_WEIGHTED: begin
        gray_d = clamp_val;
        sat_d  = clamp_sat;
      end
      default: gray_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= ctl_i.last;
    gray_q <= gray_d;
    sat_q  <= sat_d;
  end

  assign valid_o = valid_q;
  assign last_o  = last_q;
  assign gray_o  = gray_q;
  assign sat_o   = sat_q;

endmodule

// ----- rtl/core/rgb_to_gray_converter_top.sv -----
// Converts one RGB pixel per clock into a gray level through a three-stage pipeline: a pixel
// taken with start_i at one rising edge is registered by each stage in turn and appears on the
// result ports, marked by done_o, and a new pixel may be given in every cycle, so busy_o stays
// low. Stage one forms the three coefficient products, the channel sum, minimum and maximum,
// stage two adds the products with the rounding term, scales the channel sum for the average and
// forms the lightness, stage three shifts, clamps and selects by mode. Results cannot be held
// off, so the receiver must take each word in the cycle that done_o marks it. The mode and weight
// registers are read by the first stage and are to be written only while the pipeline is empty.
module rgb_to_gray_converter_top #(
  parameter int CHANNEL_BITS     = 8,
  parameter int WEIGHT_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [CHANNEL_BITS-1:0]             red_value_i,
  input  logic [CHANNEL_BITS-1:0]             green_value_i,
  input  logic [CHANNEL_BITS-1:0]             blue_value_i,
  input  logic                                last_pixel_in_i,
  output logic                                done_o,
  output logic [CHANNEL_BITS-1:0]             gray_value_o,
  output logic                                saturated_o,
  output logic                                last_pixel_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rgb2g_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rgb2g_pkg::WEIGHT_W-1:0]      cfg_data_i
);

  localparam int PROD_W    = rgb2g_pkg::COEF_W + CHANNEL_BITS + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DIV_SHIFT = ((CHANNEL_BITS + 4) / 2) * 2;
  localparam int AVG_W     = CHANNEL_BITS + 2 + DIV_SHIFT;

  rgb2g_pkg::cfg_t         cfg;
  rgb2g_pkg::pipe_ctl_t    s1_ctl, s2_ctl;
  logic signed [PROD_W-1:0] s1_prod [3];
  logic [CHANNEL_BITS+1:0] s1_sum;
  logic [CHANNEL_BITS-1:0] s1_min, s1_max, s2_min, s2_max, s2_light;
  logic signed [ACC_W-1:0] s2_acc;
  logic [AVG_W-1:0]        s2_avg_prod;
  logic                    accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rgb2g_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rgb2g_prod #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .last_i  (last_pixel_in_i),
    .red_i   (red_value_i),
    .green_i (green_value_i),
    .blue_i  (blue_value_i),
    .cfg_i   (cfg),
    .ctl_o   (s1_ctl),
    .prod_o  (s1_prod),
    .sum_o   (s1_sum),
    .min_o   (s1_min),
    .max_o   (s1_max)
  );

  rgb2g_sum #(
    .CHANNEL_BITS     (CHANNEL_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (s1_ctl),
    .prod_i     (s1_prod),
    .sum_i      (s1_sum),
    .min_i      (s1_min),
    .max_i      (s1_max),
    .ctl_o      (s2_ctl),
    .acc_o      (s2_acc),
    .avg_prod_o (s2_avg_prod),
    .light_o    (s2_light),
    .min_o      (s2_min),
    .max_o      (s2_max)
  );

  rgb2g_out #(
    .CHANNEL_BITS     (CHANNEL_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (s2_ctl),
    .acc_i      (s2_acc),
    .avg_prod_i (s2_avg_prod),
    .light_i    (s2_light),
    .min_i      (s2_min),
    .max_i      (s2_max),
    .valid_o    (done_o),
    .last_o     (last_pixel_out_o),
    .gray_o     (gray_value_o),
    .sat_o      (saturated_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("A pixel did not give a result three cycles after it was taken.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##3 !done_o)
    else $error("A result appeared without a pixel taken three cycles earlier.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 (last_pixel_out_o == $past(last_pixel_in_i, 3)))
    else $error("The last-pixel flag was not carried through the pipeline.");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |-> (gray_value_o == '0 || gray_value_o == '1))
    else $error("A clamped result is neither zero nor full scale.");

endmodule
